// ===== src/lsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_pkg
// Types, pattern codes and colour constants of the LED status pattern
// generator, and the brightness scaling function.
// ----------------------------------------------------------------------------
package lsp_pkg;

	// request codes
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	// pattern codes
	localparam logic [2:0] PAT_IDLE       = 3'd0;
	localparam logic [2:0] PAT_RECORDING  = 3'd1;
	localparam logic [2:0] PAT_PROCESSING = 3'd2;
	localparam logic [2:0] PAT_SPEAKING   = 3'd3;
	localparam logic [2:0] PAT_REMINDER   = 3'd4;
	localparam logic [2:0] PAT_OFF        = 3'd5;

	localparam logic [31:0] TICK_PERIOD_MS = 32'd50;
	localparam int          MAX_FRAME      = 16;

	localparam logic [7:0] FULL_LEVEL  = 8'd255;
	localparam logic [7:0] IDLE_BASE   = 8'd20;
	localparam logic [7:0] PROC_BASE   = 8'd100;
	localparam logic [7:0] PROC_SLOPE  = 8'd15;
	localparam logic [7:0] CHASE_ON    = 8'd255;
	localparam logic [7:0] CHASE_DIM   = 8'd30;

	// frame description handed from front to back
	typedef struct packed {
		logic       chase;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] level;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// c * level / 255, truncated; exact for all 16-bit products
	function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] level);
		logic [15:0] prod;
		logic [15:0] sum;
		prod = c * level;
		sum  = prod + {8'd0, prod[15:8]} + 16'd1;
		return sum[15:8];
	endfunction

endpackage
`default_nettype wire

// ===== src/lsp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_queue
// Two-entry queue of frame descriptions between front and back.
// ----------------------------------------------------------------------------
module lsp_queue import lsp_pkg::*; #(
	parameter int W = 33
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [W-1:0] wr_data,
	input  wire logic         rd_en,
	output logic      [W-1:0] rd_data,
	output q_stat_t           stat
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en)
				wr_ptr_q <= ~wr_ptr_q;
			if (rd_en)
				rd_ptr_q <= ~rd_ptr_q;
			if (wr_en && !rd_en)
				count_q <= count_q + 2'd1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 2'd1;
		end
	end

	// store
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

// ===== src/lsp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_front
// Accepts requests, keeps pattern, step and timing state, and turns each
// request that draws into a frame description for the queue.
// ----------------------------------------------------------------------------
module lsp_front import lsp_pkg::*; #(
	parameter int NUM_LEDS = 16,
	parameter int LIT_W    = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic             operation,
	input  wire logic [31:0]      now_ms,
	input  wire logic [2:0]       pattern,
	input  wire q_stat_t          q_stat,
	output logic                  q_push,
	output frame_t                q_frame,
	output logic      [LIT_W-1:0] q_lit
);

	logic [2:0]       pattern_q;
	logic [31:0]      step_q;
	logic [31:0]      last_ms_q;
	logic [5:0]       m60_q;    // step mod 60
	logic [4:0]       m20_q;    // step mod 20
	logic [LIT_W-1:0] lit_q;    // step mod NUM_LEDS

	logic        accept;
	logic        due;
	logic        wrap;
	logic        emit;
	logic [31:0] elapsed;
	logic [7:0]  idle_lvl;
	logic [7:0]  proc_lvl;

	assign accept  = push && !q_stat.full;
	assign elapsed = now_ms - last_ms_q;
	assign due     = (elapsed >= TICK_PERIOD_MS);
	assign wrap    = (step_q == 32'hFFFF_FFFF);

	always_comb begin
		if (m60_q < 6'd30)
			idle_lvl = IDLE_BASE + {m60_q, 2'b00};
		else
			idle_lvl = IDLE_BASE + {(6'd60 - m60_q), 2'b00};
		if (m20_q < 5'd10)
			proc_lvl = PROC_BASE + 8'({3'd0, m20_q} * PROC_SLOPE);
		else
			proc_lvl = PROC_BASE + 8'({3'd0, (5'd20 - m20_q)} * PROC_SLOPE);
	end

	// classify the request
	always_comb begin
		emit          = 1'b0;
		q_frame.chase = 1'b0;
		q_frame.r     = 8'd0;
		q_frame.g     = 8'd0;
		q_frame.b     = 8'd0;
		q_frame.level = FULL_LEVEL;
		if (operation == OP_SELECT) begin
			emit = (pattern == PAT_OFF);
		end else if (due) begin
			case (pattern_q)
				PAT_IDLE: begin
					emit          = 1'b1;
					q_frame.g     = 8'd50;
					q_frame.b     = 8'd150;
					q_frame.level = idle_lvl;
				end
				PAT_RECORDING: begin
					emit      = 1'b1;
					q_frame.g = 8'd200;
					q_frame.b = 8'd200;
				end
				PAT_PROCESSING: begin
					emit          = 1'b1;
					q_frame.r     = 8'd255;
					q_frame.g     = 8'd200;
					q_frame.level = proc_lvl;
				end
				PAT_SPEAKING: begin
					emit          = 1'b1;
					q_frame.chase = 1'b1;
				end
				PAT_REMINDER: begin
					emit = 1'b1;
					if (m20_q >= 5'd10)
						q_frame.r = 8'd255;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	assign q_push = accept && emit;
	assign q_lit  = lit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PAT_IDLE;
			step_q    <= 32'd0;
			last_ms_q <= 32'd0;
			m60_q     <= 6'd0;
			m20_q     <= 5'd0;
			lit_q     <= '0;
		end else if (accept) begin
			if (operation == OP_SELECT) begin
				pattern_q <= pattern;
				step_q    <= 32'd0;
				m60_q     <= 6'd0;
				m20_q     <= 5'd0;
				lit_q     <= '0;
			end else if (due) begin
				last_ms_q <= now_ms;
				step_q    <= step_q + 32'd1;
				// advance residues, restart all of them when the count wraps
				if (wrap || m60_q == 6'd59)
					m60_q <= 6'd0;
				else
					m60_q <= m60_q + 6'd1;
				if (wrap || m20_q == 5'd19)
					m20_q <= 5'd0;
				else
					m20_q <= m20_q + 5'd1;
				if (wrap || lit_q == LIT_W'(NUM_LEDS - 1))
					lit_q <= '0;
				else
					lit_q <= lit_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/lsp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_back
// Takes frame descriptions from the queue, scales the colour once per frame
// and emits one pixel per cycle through an output register while it is free.
// ----------------------------------------------------------------------------
module lsp_back import lsp_pkg::*; #(
	parameter int NUM_LEDS = 16,
	parameter int LIT_W    = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire q_stat_t          q_stat,
	input  wire frame_t           q_frame,
	input  wire logic [LIT_W-1:0] q_lit,
	output logic                  q_pop,
	input  wire logic             pop,
	output logic                  empty,
	output logic      [3:0]       pixel_index,
	output logic      [7:0]       red,
	output logic      [7:0]       green,
	output logic      [7:0]       blue,
	output logic                  last_pixel
);

	localparam int         FRAME_LEN = (NUM_LEDS < MAX_FRAME) ? NUM_LEDS : MAX_FRAME;
	localparam logic [3:0] LAST_IDX  = 4'(FRAME_LEN - 1);

	logic             busy_s1;
	logic             chase_s1;
	logic [7:0]       r_s1;
	logic [7:0]       g_s1;
	logic [7:0]       b_s1;
	logic [LIT_W-1:0] lit_s1;
	logic [3:0]       idx_s1;

	logic       valid_q;
	logic [3:0] pixel_index_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic       last_q;

	logic out_free;
	logic fire;
	logic done;
	logic lit_hit;

	assign out_free = !valid_q || pop;
	assign fire     = busy_s1 && out_free;
	assign done     = fire && (idx_s1 == LAST_IDX);
	assign q_pop    = !q_stat.empty && (!busy_s1 || done);
	assign lit_hit  = ({{LIT_W{1'b0}}, idx_s1} == {4'd0, lit_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			idx_s1  <= 4'd0;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_s1 <= 1'b1;
				idx_s1  <= 4'd0;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end else if (fire) begin
				idx_s1 <= idx_s1 + 4'd1;
			end
			if (out_free)
				valid_q <= busy_s1;
		end
	end

	// frame colours and pixel payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			chase_s1 <= q_frame.chase;
			r_s1     <= scale(q_frame.r, q_frame.level);
			g_s1     <= scale(q_frame.g, q_frame.level);
			b_s1     <= scale(q_frame.b, q_frame.level);
			lit_s1   <= q_lit;
		end
		if (fire) begin
			pixel_index_q <= idx_s1;
			last_q        <= (idx_s1 == LAST_IDX);
			if (chase_s1) begin
				red_q   <= 8'd0;
				green_q <= lit_hit ? CHASE_ON : CHASE_DIM;
				blue_q  <= 8'd0;
			end else begin
				red_q   <= r_s1;
				green_q <= g_s1;
				blue_q  <= b_s1;
			end
		end
	end

	assign empty       = !valid_q;
	assign pixel_index = pixel_index_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;
	assign last_pixel  = last_q;

endmodule
`default_nettype wire

// ===== src/led_status_pattern_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led_status_pattern_generator
// Status animations for a strip of NUM_LEDS pixels, one pixel per result.
// ----------------------------------------------------------------------------
// Push a request with operation = tick (0) and the time in now_ms, or with
// operation = select (1) and a pattern code. A select stores the pattern and
// restarts the animation; selecting off sends one all-black frame. A tick at
// least 50 ms after the last update sends one frame for the current pattern:
// blue breathing, steady cyan, amber breathing, green chase or red blink;
// under off or a spare code it sends nothing but still records the time and
// steps the animation. A frame is min(NUM_LEDS, 16) pixels, delivered one per
// clock cycle at best, a rate that the pixel emitter in the back end sets.
// Requests that draw nothing are taken at one per cycle while full is low. A
// two-frame queue parts the request side from the pixel side, so full rises
// only while two frames wait behind the one being sent. last_pixel marks the
// final pixel of every frame.
// ----------------------------------------------------------------------------
module led_status_pattern_generator import lsp_pkg::*; #(
	parameter int NUM_LEDS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        operation,
	input  wire logic [31:0] now_ms,
	input  wire logic [2:0]  pattern,
	output logic             empty,
	input  wire logic        pop,
	output logic      [3:0]  pixel_index,
	output logic      [7:0]  red,
	output logic      [7:0]  green,
	output logic      [7:0]  blue,
	output logic             last_pixel
);

	// chase position width, at least one bit for a single-pixel strip
	localparam int LIT_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int QW        = $bits(frame_t) + LIT_W;
	localparam int FRAME_LEN = (NUM_LEDS < MAX_FRAME) ? NUM_LEDS : MAX_FRAME;

	q_stat_t          q_stat;
	logic             q_push;
	logic             q_pop;
	frame_t           wr_frame;
	logic [LIT_W-1:0] wr_lit;
	logic [QW-1:0]    rd_data;
	frame_t           rd_frame;
	logic [LIT_W-1:0] rd_lit;

	// hold requests back only while the queue has no room
	assign full = q_stat.full;

	// front: take requests, advance the animation state, describe frames
	lsp_front #(
		.NUM_LEDS (NUM_LEDS),
		.LIT_W    (LIT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.operation (operation),
		.now_ms    (now_ms),
		.pattern   (pattern),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_frame   (wr_frame),
		.q_lit     (wr_lit)
	);

	// queue of pending frames
	lsp_queue #(
		.W (QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data ({wr_frame, wr_lit}),
		.rd_en   (q_pop),
		.rd_data (rd_data),
		.stat    (q_stat)
	);

	assign rd_frame = frame_t'(rd_data[QW-1:LIT_W]);
	assign rd_lit   = rd_data[LIT_W-1:0];

	// back: scale colours and drop pixels into the output register
	lsp_back #(
		.NUM_LEDS (NUM_LEDS),
		.LIT_W    (LIT_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_frame     (rd_frame),
		.q_lit       (rd_lit),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last_pixel  (last_pixel)
	);

`ifndef SYNTHESIS
	// the frame-end mark sits exactly on the final pixel index
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_pixel == (pixel_index == 4'(FRAME_LEN - 1))))
		else $error("last_pixel does not match the final pixel index");

	// within a frame, pixels follow one another without a gap
	a_pixel_order: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_pixel) ##1 !empty
		|-> (pixel_index == $past(pixel_index) + 4'd1))
		else $error("pixel index skipped within a frame");
`endif

endmodule
`default_nettype wire
